### rtl/core/d2i_pkg.sv
package d2i_pkg;

  typedef struct packed {
    logic [63:0] double_bits;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0] int_result;
    logic        last_out;
  } out_item_t;

  // Target kind codes
  localparam logic [2:0] KIND_S8  = 3'd0;
  localparam logic [2:0] KIND_S16 = 3'd1;
  localparam logic [2:0] KIND_S32 = 3'd2;
  localparam logic [2:0] KIND_S64 = 3'd3;
  localparam logic [2:0] KIND_U8  = 3'd4;
  localparam logic [2:0] KIND_U16 = 3'd5;
  localparam logic [2:0] KIND_U32 = 3'd6;
  localparam logic [2:0] KIND_U64 = 3'd7;

  localparam logic [10:0] EXP_MAX = 11'h7FF;
  localparam logic [10:0] EXP_INT = 11'd1075;   // exponent where the LSB weighs 1
  localparam logic [10:0] EXP_TOP = 11'd1087;   // magnitude reaches 2^64 from here

  // Decoded source after stage 1
  typedef struct packed {
    logic        neg;
    logic        nan;
    logic        huge;
    logic        zero;
    logic        left;      // shift mantissa left
    logic [5:0]  sh;        // shift amount (left: 0..11, right: 1..53)
    logic [52:0] mant;
    logic        last;
  } dec_t;

  // Rounded magnitude after stage 2
  typedef struct packed {
    logic        neg;
    logic        huge;
    logic [63:0] mag;
    logic        last;
  } mag_t;

endpackage

### rtl/core/d2i_decode.sv
module d2i_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  d2i_pkg::in_item_t din,
  output logic              vout,
  output d2i_pkg::dec_t     dout
);
  import d2i_pkg::*;

  logic [10:0] e;
  logic [51:0] f;
  dec_t        d_next;

  // Field split and shift planning
  always_comb begin
    e = din.double_bits[62:52];
    f = din.double_bits[51:0];
    d_next.neg  = din.double_bits[63];
    d_next.nan  = (e == EXP_MAX) && (f != '0);
    d_next.huge = (e >= EXP_TOP);
    d_next.left = (e >= EXP_INT);
    d_next.mant = {1'b1, f};
    d_next.last = din.last_in;
    d_next.zero = (e == '0) || (e < EXP_INT - 11'd53);
    if (e >= EXP_INT) begin
      d_next.sh = 6'((e - EXP_INT) & 11'h3F);
    end else begin
      d_next.sh = 6'((EXP_INT - e) & 11'h3F);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout <= d_next;
    end
  end

endmodule

### rtl/core/d2i_round.sv
module d2i_round (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  d2i_pkg::dec_t din,
  output logic          vout,
  output d2i_pkg::mag_t dout
);
  import d2i_pkg::*;

  logic [53:0] rsh;
  mag_t        m_next;

  // Shift mantissa and round half away from zero
  always_comb begin
    rsh = {din.mant, 1'b0} >> din.sh;   // keeps the half bit at [0]
    m_next.neg  = din.neg && !din.nan;
    m_next.huge = din.huge && !din.nan;
    m_next.last = din.last;
    if (din.nan || din.zero || din.huge) begin
      m_next.mag = '0;
    end else if (din.left) begin
      m_next.mag = {11'd0, din.mant} << din.sh;
    end else begin
      m_next.mag = {11'd0, rsh[53:1]} + {63'd0, rsh[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout <= m_next;
    end
  end

endmodule

### rtl/core/d2i_clamp.sv
module d2i_clamp (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [2:0]        kind,
  input  d2i_pkg::mag_t     din,
  output logic              vout,
  output d2i_pkg::out_item_t dout
);
  import d2i_pkg::*;

  logic [63:0] umax;
  logic [63:0] half;
  logic [63:0] res;

  // Range limits and saturation
  always_comb begin
    case (kind[1:0])
      2'd0:    umax = 64'hFF;
      2'd1:    umax = 64'hFFFF;
      2'd2:    umax = 64'hFFFF_FFFF;
      default: umax = '1;
    endcase
    half = (umax >> 1) + 64'd1;
    if (!kind[2]) begin
      if (!din.neg) begin
        res = (din.huge || din.mag > half - 64'd1) ? half - 64'd1 : din.mag;
      end else begin
        res = 64'd0 - ((din.huge || din.mag > half) ? half : din.mag);
      end
    end else if (din.neg) begin
      res = '0;
    end else begin
      res = (din.huge || din.mag > umax) ? umax : din.mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout.int_result <= res;
      dout.last_out   <= din.last;
    end
  end

endmodule

### rtl/core/double_to_int_saturating_round.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall   | in_data (double_bits, last_in)
// out     | output    | out_valid / out_stall | out_data (int_result, last_out)
// cfg     | input     | cfg_we                | cfg_data (target_kind)
// Three register stages (decode, round, clamp), one transaction per cycle
// sustained while out is not stalled. A stall on out freezes the whole pipe;
// in_stall is out_stall while the last stage holds a result.
// Synchronous reset clears the valid bits and sets target_kind to signed int8.
module double_to_int_saturating_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  d2i_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output d2i_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_data
);
  import d2i_pkg::*;

  logic       en;
  logic       v1;
  logic       v2;
  dec_t       s1;
  mag_t       s2;
  logic [2:0] kind;

  // Pipe advances unless a held result is stalled
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= '0;
    end else if (cfg_we) begin
      kind <= cfg_data;
    end
  end

  d2i_decode u_dec (
    .clk(clk), .rst(rst), .en(en), .vin(in_valid), .din(in_data), .vout(v1), .dout(s1)
  );

  d2i_round u_rnd (
    .clk(clk), .rst(rst), .en(en), .vin(v1), .din(s1), .vout(v2), .dout(s2)
  );

  d2i_clamp u_clp (
    .clk(clk), .rst(rst), .en(en), .vin(v2), .kind(kind), .din(s2),
    .vout(out_valid), .dout(out_data)
  );

  // Held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");

  // Input stalls only while a held result is stalled
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");

  // A uint8 result never leaves the 8-bit range
  a_u8: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(en) && $past(kind) == KIND_U8 && $stable(kind) |->
      out_data.int_result[63:8] == '0)
    else $error("uint8 result out of range");

endmodule
